// ===== hdl/dvrt_pkg.sv =====
// Package for the distance-vector route table core: request codes, widths and
// the sequencer state type. No dependencies.
package dvrt_pkg;

	localparam int unsigned DefaultRouteEntries = 32;
	localparam int unsigned IdWidth = 8;
	localparam int unsigned TimeWidth = 32;
	localparam int unsigned NumPorts = 4;

	typedef enum logic [2:0] {
		REQ_PING     = 3'd0,
		REQ_NEW_NBR  = 3'd1,
		REQ_ADVERT   = 3'd2,
		REQ_DELETE   = 3'd3,
		REQ_LOOKUP   = 3'd4
	} req_type_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_APPEND,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/distance_vector_route_table_core.sv =====
// Distance-vector route table core: one route memory with a sequencer that
// scans, updates, appends and compacts entries. Depends on dvrt_pkg.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the single result word is shown on the result ports for one cycle,
// marked by done. The receiver cannot stall, so results must be consumed as
// they appear. The scan issues the read of one route in ST_SCAN from a memory
// with a registered read port, and compares the registered read data in ST_CHECK
// before the next route is read. A delete moves each later entry up through
// ST_SHIFT_RD and ST_SHIFT_WR to close the gap. Pings and unknown request
// codes go straight to ST_DONE. Routes are kept in one memory of ROUTE_ENTRIES
// words holding destination, next hop and hop count; only entries below the
// route count are ever used, so no clearing pass is needed. Neighbor ids and
// last-heard times are four small register pairs. The own_id_q register is
// written through the cfg channel, which is always ready.
module distance_vector_route_table_core
	import dvrt_pkg::*;
#(
	parameter int unsigned ROUTE_ENTRIES = DefaultRouteEntries
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IdWidth-1:0]   cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           req_type,
	input  logic [1:0]           port,
	input  logic [IdWidth-1:0]   sender_id,
	input  logic [IdWidth-1:0]   entry_dest,
	input  logic [IdWidth-1:0]   entry_next_hop,
	input  logic [IdWidth-1:0]   entry_hops,
	input  logic [IdWidth-1:0]   target_id,
	input  logic [TimeWidth-1:0] now_seconds,
	output logic                 done,
	output logic                 table_changed,
	output logic                 send_delete,
	output logic                 send_new_here,
	output logic [1:0]           out_port,
	output logic                 port_found,
	output logic                 for_me,
	output logic                 table_full
);

	localparam int unsigned AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ROUTE_ENTRIES + 1);
	localparam logic [CW-1:0] CntMax = CW'(ROUTE_ENTRIES);
	localparam int unsigned RW = 3 * IdWidth;

	// Route memory word: {dest, next, hops}.
	logic [RW-1:0] route_mem [ROUTE_ENTRIES];
	logic [RW-1:0] rd_data_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [RW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			route_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= route_mem[mem_raddr];
	end

	state_t state_q, state_d;
	logic [IdWidth-1:0]   own_id_q;
	logic [CW-1:0]        count_q, count_d;
	logic [CW-1:0]        idx_q, idx_d;
	logic [IdWidth-1:0]   nbr_id_q [NumPorts];
	logic [TimeWidth-1:0] nbr_heard_q [NumPorts];

	// Captured request.
	logic [2:0]         req_q;
	logic [1:0]         port_q;
	logic [IdWidth-1:0] sender_q, edest_q, enext_q, nh_q, target_q;

	// Result accumulators.
	logic changed_q, changed_d, sdel_q, sdel_d, newhere_q, newhere_d;
	logic [1:0] oport_q, oport_d;
	logic found_q, found_d, forme_q, forme_d, full_q, full_d, match_q, match_d;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign table_changed = changed_q;
	assign send_delete   = sdel_q;
	assign send_new_here = newhere_q;
	assign out_port      = oport_q;
	assign port_found    = found_q;
	assign for_me        = forme_q;
	assign table_full    = full_q;

	logic accept;
	assign accept = start && !busy;

	logic [IdWidth-1:0] rd_dest, rd_next, rd_hops;
	assign rd_dest = rd_data_q[RW-1 -: IdWidth];
	assign rd_next = rd_data_q[2*IdWidth-1 -: IdWidth];
	assign rd_hops = rd_data_q[IdWidth-1:0];

	logic [IdWidth-1:0] via;
	assign via = nbr_id_q[port_q];

	// Neighbor match for a lookup, first port wins.
	logic       nbr_hit;
	logic [1:0] nbr_port;
	always_comb begin
		nbr_hit = 1'b0;
		nbr_port = 2'd0;
		for (int p = NumPorts - 1; p >= 0; p--) begin
			if (nbr_id_q[p] == rd_next) begin
				nbr_hit = 1'b1;
				nbr_port = 2'(p);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idx_d = idx_q;
		changed_d = changed_q;
		sdel_d = sdel_q;
		newhere_d = newhere_q;
		oport_d = oport_q;
		found_d = found_q;
		forme_d = forme_q;
		full_d = full_q;
		match_d = match_q;
		mem_we = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = rd_data_q;
		mem_raddr = idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_d = '0;
					changed_d = 1'b0;
					sdel_d = 1'b0;
					newhere_d = (req_type == REQ_DELETE) && (target_id == own_id_q);
					oport_d = 2'd0;
					found_d = 1'b0;
					forme_d = (req_type == REQ_LOOKUP) && (target_id == own_id_q);
					full_d = 1'b0;
					match_d = 1'b0;
					case (req_type)
						REQ_NEW_NBR: state_d = ST_APPEND;
						REQ_ADVERT, REQ_DELETE: state_d = ST_SCAN;
						REQ_LOOKUP: state_d = (target_id == own_id_q) ? ST_DONE : ST_SCAN;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				// Read of entry idx issued; data valid in ST_CHECK.
				if (idx_q >= count_q) begin
					state_d = ((req_q == REQ_ADVERT) && !match_q && (edest_q != own_id_q))
						? ST_APPEND : ST_DONE;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ST_SCAN;
				idx_d = idx_q + CW'(1);
				if (rd_dest == ((req_q == REQ_ADVERT) ? edest_q : target_q)) begin
					case (req_q)
						REQ_ADVERT: begin
							match_d = 1'b1;
							if (rd_hops > nh_q) begin
								mem_we = 1'b1;
								mem_wdata = {rd_dest, via, nh_q};
								changed_d = 1'b1;
							end
						end
						REQ_DELETE: begin
							if (rd_next == sender_q) begin
								sdel_d = 1'b1;
								count_d = count_q - CW'(1);
								idx_d = idx_q;
								state_d = ST_SHIFT_RD;
							end else begin
								changed_d = 1'b1;
								state_d = ST_DONE;
							end
						end
						REQ_LOOKUP: begin
							found_d = nbr_hit;
							oport_d = nbr_port;
							state_d = ST_DONE;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SHIFT_RD: begin
				// idx is the hole; count already reduced.
				mem_raddr = AW'(idx_q + CW'(1));
				state_d = (idx_q >= count_q) ? ST_DONE : ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				mem_we = 1'b1;
				idx_d = idx_q + CW'(1);
				state_d = ST_SHIFT_RD;
			end
			ST_APPEND: begin
				if (count_q >= CntMax) begin
					full_d = 1'b1;
				end else begin
					mem_we = 1'b1;
					mem_waddr = count_q[AW-1:0];
					mem_wdata = (req_q == REQ_NEW_NBR) ?
						{sender_q, sender_q, IdWidth'(1)} : {edest_q, enext_q, nh_q};
					count_d = count_q + CW'(1);
					changed_d = 1'b1;
				end
				state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			own_id_q <= '0;
			for (int p = 0; p < NumPorts; p++) begin
				nbr_id_q[p] <= '0;
				nbr_heard_q[p] <= '0;
			end
			changed_q <= 1'b0;
			sdel_q <= 1'b0;
			newhere_q <= 1'b0;
			oport_q <= 2'd0;
			found_q <= 1'b0;
			forme_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			changed_q <= changed_d;
			sdel_q <= sdel_d;
			newhere_q <= newhere_d;
			oport_q <= oport_d;
			found_q <= found_d;
			forme_q <= forme_d;
			full_q <= full_d;
			if (cfg_valid && cfg_ready) begin
				own_id_q <= cfg_data;
			end
			if (accept && (req_type == REQ_PING || req_type == REQ_NEW_NBR)) begin
				nbr_heard_q[port] <= now_seconds;
				if (req_type == REQ_NEW_NBR) begin
					nbr_id_q[port] <= sender_id;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		match_q <= match_d;
		if (accept) begin
			req_q <= req_type;
			port_q <= port;
			sender_q <= sender_id;
			edest_q <= entry_dest;
			enext_q <= entry_next_hop;
			nh_q <= (entry_hops == '1) ? entry_hops : entry_hops + IdWidth'(1);
			target_q <= target_id;
		end
	end

	// The route count never exceeds the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntMax) else $error("route count overflow");

	// A dropped insert never also reports a change.
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(table_full && table_changed)) else $error("full and changed");

	// A finished item returns to idle in the next cycle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("done not followed by idle");

	// A removal always shrinks the table by one.
	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && state_d == ST_SHIFT_RD) |=> count_q == $past(count_q) - CW'(1))
		else $error("delete did not shrink table");

endmodule

// ===== bench/distance_vector_route_table_core_tb.sv =====
// Testbench for distance_vector_route_table_core: directed and random control requests,
// checked against a behavioral route table kept inside the bench. Depends on dvrt_pkg and the core.
module distance_vector_route_table_core_tb;
	import dvrt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RouteDepth = DefaultRouteEntries;
	localparam int unsigned CycleLimit = 3000000;
	// Request codes above the last defined one must be ignored by the core.
	localparam logic [2:0] REQ_RESERVED_MAX = 3'd7;

	typedef struct packed {
		logic [2:0]           kind;
		logic [1:0]           port;
		logic [IdWidth-1:0]   sender;
		logic [IdWidth-1:0]   dest;
		logic [IdWidth-1:0]   next_hop;
		logic [IdWidth-1:0]   hops;
		logic [IdWidth-1:0]   target;
		logic [TimeWidth-1:0] now;
	} request_t;

	typedef struct packed {
		logic       changed;
		logic       del;
		logic       new_here;
		logic [1:0] out_port;
		logic       found;
		logic       for_me;
		logic       full;
	} reply_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [IdWidth-1:0]   cfg_data;
	logic                 start;
	logic                 busy;
	logic [2:0]           req_type;
	logic [1:0]           port;
	logic [IdWidth-1:0]   sender_id;
	logic [IdWidth-1:0]   entry_dest;
	logic [IdWidth-1:0]   entry_next_hop;
	logic [IdWidth-1:0]   entry_hops;
	logic [IdWidth-1:0]   target_id;
	logic [TimeWidth-1:0] now_seconds;
	logic                 done;
	logic                 table_changed;
	logic                 send_delete;
	logic                 send_new_here;
	logic [1:0]           out_port;
	logic                 port_found;
	logic                 for_me;
	logic                 table_full;

	// Shadow copy of the route table, neighbor table and node id register.
	logic [IdWidth-1:0]   rt_dest [RouteDepth];
	logic [IdWidth-1:0]   rt_next [RouteDepth];
	logic [IdWidth-1:0]   rt_hops [RouteDepth];
	int unsigned          rt_count;
	logic [IdWidth-1:0]   nbr_id [NumPorts];
	logic [TimeWidth-1:0] nbr_heard [NumPorts];
	logic [IdWidth-1:0]   my_id;

	reply_t      pending_replies[$];
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned burst_left;

	distance_vector_route_table_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.port          (port),
		.sender_id     (sender_id),
		.entry_dest    (entry_dest),
		.entry_next_hop(entry_next_hop),
		.entry_hops    (entry_hops),
		.target_id     (target_id),
		.now_seconds   (now_seconds),
		.done          (done),
		.table_changed (table_changed),
		.send_delete   (send_delete),
		.send_new_here (send_new_here),
		.out_port      (out_port),
		.port_found    (port_found),
		.for_me        (for_me),
		.table_full    (table_full)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("distance_vector_route_table_core_tb: done, errors");
			$finish;
		end
	end

	// Appends one route; returns 0 when the table has no room.
	function automatic bit route_append(logic [IdWidth-1:0] d, logic [IdWidth-1:0] n,
			logic [IdWidth-1:0] h);
		if (rt_count >= RouteDepth)
			return 1'b0;
		rt_dest[rt_count] = d;
		rt_next[rt_count] = n;
		rt_hops[rt_count] = h;
		rt_count++;
		return 1'b1;
	endfunction

	// Applies one request to the shadow tables and returns the reply word the core
	// should produce for it.
	function automatic reply_t route_update(request_t rq);
		reply_t           r;
		logic [IdWidth-1:0] via;
		logic [IdWidth-1:0] new_hops;
		bit               matched;
		r = '0;
		case (rq.kind)
			REQ_PING: begin
				nbr_heard[rq.port] = rq.now;
			end
			REQ_NEW_NBR: begin
				nbr_id[rq.port] = rq.sender;
				nbr_heard[rq.port] = rq.now;
				if (route_append(rq.sender, rq.sender, 8'd1))
					r.changed = 1'b1;
				else
					r.full = 1'b1;
			end
			REQ_ADVERT: begin
				via = nbr_id[rq.port];
				new_hops = (rq.hops == 8'hFF) ? 8'hFF : rq.hops + 8'd1;
				matched = 1'b0;
				// Every entry for the destination is considered, not just the first.
				for (int i = 0; i < rt_count; i++) begin
					if (rt_dest[i] == rq.dest) begin
						if (rt_hops[i] > new_hops) begin
							rt_next[i] = via;
							rt_hops[i] = new_hops;
							r.changed = 1'b1;
						end
						matched = 1'b1;
					end
				end
				if (!matched && rq.dest != my_id) begin
					if (route_append(rq.dest, rq.next_hop, new_hops))
						r.changed = 1'b1;
					else
						r.full = 1'b1;
				end
			end
			REQ_DELETE: begin
				if (rq.target == my_id)
					r.new_here = 1'b1;
				for (int i = 0; i < rt_count; i++) begin
					if (rt_dest[i] == rq.target) begin
						if (rt_next[i] == rq.sender) begin
							for (int j = i; j + 1 < rt_count; j++) begin
								rt_dest[j] = rt_dest[j+1];
								rt_next[j] = rt_next[j+1];
								rt_hops[j] = rt_hops[j+1];
							end
							rt_count--;
							r.del = 1'b1;
						end else begin
							r.changed = 1'b1;
						end
						break;
					end
				end
			end
			REQ_LOOKUP: begin
				if (rq.target == my_id) begin
					r.for_me = 1'b1;
				end else begin
					for (int i = 0; i < rt_count; i++) begin
						if (rt_dest[i] == rq.target) begin
							for (int p = 0; p < NumPorts; p++) begin
								if (nbr_id[p] == rt_next[i]) begin
									r.out_port = p[1:0];
									r.found = 1'b1;
									break;
								end
							end
							break;
						end
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Results are sampled on the falling edge, away from the core's register updates.
	always @(negedge clk) begin
		reply_t exp_r;
		reply_t got;
		if (arst_n && done) begin
			got = '{table_changed, send_delete, send_new_here, out_port, port_found,
				for_me, table_full};
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				error_count++;
			end else begin
				exp_r = pending_replies.pop_front();
				if (got.changed !== exp_r.changed) begin
					$display("%0t: table_changed expected %b got %b", $time,
						exp_r.changed, got.changed);
					error_count++;
				end
				if (got.del !== exp_r.del) begin
					$display("%0t: send_delete expected %b got %b", $time, exp_r.del, got.del);
					error_count++;
				end
				if (got.new_here !== exp_r.new_here) begin
					$display("%0t: send_new_here expected %b got %b", $time,
						exp_r.new_here, got.new_here);
					error_count++;
				end
				if (got.out_port !== exp_r.out_port) begin
					$display("%0t: out_port expected %0d got %0d", $time,
						exp_r.out_port, got.out_port);
					error_count++;
				end
				if (got.found !== exp_r.found) begin
					$display("%0t: port_found expected %b got %b", $time, exp_r.found, got.found);
					error_count++;
				end
				if (got.for_me !== exp_r.for_me) begin
					$display("%0t: for_me expected %b got %b", $time, exp_r.for_me, got.for_me);
					error_count++;
				end
				if (got.full !== exp_r.full) begin
					$display("%0t: table_full expected %b got %b", $time, exp_r.full, got.full);
					error_count++;
				end
			end
		end
	end

	// Called right after a rising edge. Drives one request word and returns at the edge
	// that accepts it; the caller may chain the next word in the same time step.
	task automatic send_request(request_t rq);
		start          <= 1'b1;
		req_type       <= rq.kind;
		port           <= rq.port;
		sender_id      <= rq.sender;
		entry_dest     <= rq.dest;
		entry_next_hop <= rq.next_hop;
		entry_hops     <= rq.hops;
		target_id      <= rq.target;
		now_seconds    <= rq.now;
		@(negedge clk);
		while (busy) begin
			@(negedge clk);
		end
		@(posedge clk);
		pending_replies.push_back(route_update(rq));
	endtask

	// Sender pacing: bursts of back-to-back words separated by random gaps.
	task automatic sender_pause();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
		gap = $urandom_range(1, 10);
		start <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic send_paced(request_t rq);
		send_request(rq);
		sender_pause();
	endtask

	// Waits for every outstanding result, then lets the sequencer settle.
	task automatic drain();
		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_node_id(logic [IdWidth-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		my_id = v;
	endtask

	// Ids are mostly drawn from a small pool so that routes collide and match.
	function automatic logic [IdWidth-1:0] pick_id();
		if ($urandom_range(0, 9) == 0)
			return IdWidth'($urandom_range(0, 255));
		return IdWidth'($urandom_range(0, 11));
	endfunction

	function automatic request_t make_req(logic [2:0] k, logic [1:0] p, logic [IdWidth-1:0] s,
			logic [IdWidth-1:0] d, logic [IdWidth-1:0] n, logic [IdWidth-1:0] h,
			logic [IdWidth-1:0] t);
		request_t rq;
		rq = '{k, p, s, d, n, h, t, $urandom()};
		return rq;
	endfunction

	function automatic request_t random_req();
		request_t    rq;
		int unsigned pick;
		int unsigned idx;
		rq = '{3'($urandom()), 2'($urandom()), IdWidth'($urandom()), IdWidth'($urandom()),
			IdWidth'($urandom()), IdWidth'($urandom()), IdWidth'($urandom()), $urandom()};
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			rq.kind = REQ_PING;
		end else if (pick < 30) begin
			rq.kind = REQ_NEW_NBR;
			rq.sender = pick_id();
		end else if (pick < 58) begin
			rq.kind = REQ_ADVERT;
			rq.dest = pick_id();
			rq.next_hop = pick_id();
			case ($urandom_range(0, 5))
				0:       rq.hops = 8'hFF;
				1:       rq.hops = IdWidth'($urandom_range(0, 255));
				default: rq.hops = IdWidth'($urandom_range(0, 6));
			endcase
		end else if (pick < 80) begin
			rq.kind = REQ_DELETE;
			rq.target = pick_id();
			rq.sender = pick_id();
			if (rt_count > 0 && $urandom_range(0, 3) != 0) begin
				idx = $urandom_range(0, rt_count - 1);
				rq.target = rt_dest[idx];
				if ($urandom_range(0, 9) < 7)
					rq.sender = rt_next[idx];
			end
		end else if (pick < 96) begin
			rq.kind = REQ_LOOKUP;
			rq.target = pick_id();
			if (rt_count > 0 && $urandom_range(0, 9) < 7)
				rq.target = rt_dest[$urandom_range(0, rt_count - 1)];
			else if ($urandom_range(0, 9) == 0)
				rq.target = my_id;
		end else begin
			rq.kind = 3'($urandom_range(REQ_LOOKUP + 1, REQ_RESERVED_MAX));
		end
		return rq;
	endfunction

	// Directed pass: extremes, every request code and the named corner cases.
	task automatic test_directed();
		// Lookup of our own id on an empty table, then a miss on an empty table.
		send_paced(make_req(REQ_LOOKUP, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_paced(make_req(REQ_LOOKUP, 2'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd9));
		send_paced('{REQ_PING, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF});
		send_paced(make_req(REQ_NEW_NBR, 2'd0, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0));
		send_paced(make_req(REQ_NEW_NBR, 2'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0));
		// A second new-neighbor for the same sender appends a duplicate route.
		send_paced(make_req(REQ_NEW_NBR, 2'd2, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0));
		// Unknown destination with the largest hop count saturates instead of wrapping.
		send_paced(make_req(REQ_ADVERT, 2'd0, 8'd0, 8'd7, 8'd5, 8'hFF, 8'd0));
		// Advertising our own id is ignored.
		send_paced(make_req(REQ_ADVERT, 2'd0, 8'd0, 8'd0, 8'd5, 8'd0, 8'd0));
		// A shorter path to 7 through port 1, then a longer one that changes nothing.
		send_paced(make_req(REQ_ADVERT, 2'd1, 8'd0, 8'd7, 8'd3, 8'd0, 8'd0));
		send_paced(make_req(REQ_ADVERT, 2'd0, 8'd0, 8'd7, 8'd3, 8'd4, 8'd0));
		// Duplicate routes to 1 both see the advertisement.
		send_paced(make_req(REQ_ADVERT, 2'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0));
		// Lookups: a hit, a route whose next hop no neighbor holds, and a miss.
		send_paced(make_req(REQ_LOOKUP, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd7));
		send_paced(make_req(REQ_ADVERT, 2'd2, 8'd0, 8'd40, 8'd99, 8'd2, 8'd0));
		send_paced(make_req(REQ_LOOKUP, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd40));
		send_paced(make_req(REQ_LOOKUP, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFE));
		// Deletes: two with a wrong next hop, our own id, unknown target.
		send_paced(make_req(REQ_DELETE, 2'd0, 8'd3, 8'd0, 8'd0, 8'd0, 8'd1));
		send_paced(make_req(REQ_DELETE, 2'd0, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd1));
		send_paced(make_req(REQ_DELETE, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_paced(make_req(REQ_DELETE, 2'd3, 8'd5, 8'd0, 8'd0, 8'd0, 8'd200));
		// Unused neighbor ports hold id 0 and match a next hop of 0.
		send_paced(make_req(REQ_ADVERT, 2'd3, 8'd0, 8'd50, 8'd0, 8'd1, 8'd0));
		send_paced(make_req(REQ_LOOKUP, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd50));
		for (int k = REQ_LOOKUP + 1; k <= REQ_RESERVED_MAX; k++)
			send_paced('{k[2:0], 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF});
	endtask

	// Fills the table to its limit so that further inserts are dropped.
	task automatic test_full_table();
		request_t rq;
		while (rt_count < RouteDepth + 2) begin
			rq = make_req(REQ_NEW_NBR, 2'($urandom()), pick_id(), 8'd0, 8'd0, 8'd0, 8'd0);
			send_paced(rq);
			if (rt_count == RouteDepth)
				break;
		end
		send_paced(make_req(REQ_NEW_NBR, 2'd2, 8'd77, 8'd0, 8'd0, 8'd0, 8'd0));
		send_paced(make_req(REQ_ADVERT, 2'd2, 8'd0, 8'd201, 8'd3, 8'd1, 8'd0));
		send_paced(make_req(REQ_LOOKUP, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, rt_dest[RouteDepth-1]));
		// Removing the first entry shifts the whole table.
		send_paced(make_req(REQ_DELETE, 2'd0, rt_next[0], 8'd0, 8'd0, 8'd0, rt_dest[0]));
	endtask

	task automatic test_random(int unsigned n);
		repeat (n)
			send_paced(random_req());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		start = 1'b0;
		req_type = '0;
		port = '0;
		sender_id = '0;
		entry_dest = '0;
		entry_next_hop = '0;
		entry_hops = '0;
		target_id = '0;
		now_seconds = '0;
		error_count = 0;
		cycle_count = 0;
		burst_left = 0;
		rt_count = 0;
		my_id = '0;
		for (int p = 0; p < NumPorts; p++) begin
			nbr_id[p] = '0;
			nbr_heard[p] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The node id starts at its reset value of zero.
		test_directed();
		test_full_table();
		test_random(180);
		write_node_id(8'hFF);
		test_random(180);
		write_node_id(8'd5);
		test_random(180);
		write_node_id(IdWidth'($urandom_range(0, 255)));
		test_random(180);
		write_node_id(8'd0);
		test_random(50);
		drain();

		if (error_count == 0)
			$display("distance_vector_route_table_core_tb: done, clean");
		else
			$display("distance_vector_route_table_core_tb: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/dvrt_pkg.sv
hdl/distance_vector_route_table_core.sv
bench/distance_vector_route_table_core_tb.sv
